### rtl/ntc_thermistor_linearizer_unit_defines.svh
// Assertion shorthands shared by the linearizer modules.
`ifndef NTC_THERMISTOR_LINEARIZER_UNIT_DEFINES_SVH
`define NTC_THERMISTOR_LINEARIZER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define NTCL_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("ntcl assertion failed");

// Next-cycle implication.
`define NTCL_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("ntcl assertion failed");

`endif

### rtl/ntcl_pkg.sv
package ntcl_pkg;

	localparam int ADC_BITS = 12;
	localparam int SAMPLES_PER_READING = 4;
	localparam int SAMPLE_FIELDS = 4;
	localparam int SamplesUsed = (SAMPLES_PER_READING > SAMPLE_FIELDS) ? SAMPLE_FIELDS :
		((SAMPLES_PER_READING < 1) ? 1 : SAMPLES_PER_READING);
	localparam int FULL_SCALE = (1 << ADC_BITS) - 1;
	localparam int RAIL_MARGIN = 8;

	localparam int LG_ITERS = 16;
	localparam int DIV_BITS = 54;
	localparam int CNT_W = 6;

	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [14:0] T0_CENTI = 15'd29815;
	localparam logic [22:0] BETA_SCALE = 23'd6553600;
	localparam logic signed [56:0] ZERO_C_Q8 = 57'sd69926;
	localparam logic signed [15:0] LOW_LIMIT_Q8 = -16'sd14080;
	localparam logic signed [15:0] HIGH_LIMIT_Q8 = 16'sd32000;
	localparam logic signed [15:0] FAIL_Q8 = -16'sd32512;
	localparam logic signed [15:0] MAX_Q8 = 16'sd32767;
	localparam logic signed [15:0] MIN_Q8 = -16'sd32768;

	localparam logic [19:0] SERIES_RST = 20'd10000;
	localparam logic [19:0] NOMINAL_RST = 20'd10000;
	localparam logic [13:0] BETA_RST = 14'd3950;

	typedef enum logic [2:0] {
		CFG_SERIES = 3'd0,
		CFG_NOMINAL = 3'd1,
		CFG_BETA = 3'd2,
		CFG_OFFSET = 3'd3,
		CFG_ALPHA = 3'd4,
		CFG_HIGH_SIDE = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [11:0] sample_0;
		logic [11:0] sample_1;
		logic [11:0] sample_2;
		logic [11:0] sample_3;
	} in_item_t;

	typedef struct packed {
		logic [11:0] raw_average;
		logic signed [15:0] reading_q8;
		logic reading_ok;
		logic signed [15:0] temperature_q8;
		logic temperature_valid;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_LG_INIT,
		OP_LG_ITER,
		OP_LG_ACC,
		OP_LN_MUL,
		OP_LN_RND,
		OP_MUL_NUM,
		OP_MUL_BD,
		OP_MUL_LQ,
		OP_DEN,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_FIN,
		OP_BL_MUL,
		OP_UPD,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
		logic [1:0] lg_sel;
	} cmd_t;

	typedef struct packed {
		logic rail;
		logic den_zero;
		logic out_free;
	} status_t;

endpackage

### rtl/ntc_thermistor_linearizer_unit.sv
// NTC thermistor linearizer: each request carries four 12-bit ADC samples; the
// block floors their mean, derives the NTC resistance ratio from the divider,
// applies the beta equation with a squaring log2, and returns one result per
// request with the raw mean, the fresh Q8.8 Celsius reading, its range flag,
// and the exponentially smoothed temperature. A converted reading runs four
// 16-step log2 evaluations on one squaring multiplier and a 54-step
// restoring divider between accept and result. A mean at either rail skips
// both and finishes early. One request is worked at a time; the next is
// taken while a finished result waits in the output register. Configuration
// writes take effect at once and belong in idle time.
module ntc_thermistor_linearizer_unit
	import ntcl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [2:0] cfg_index,
	input logic [19:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data
);

	cmd_t cmd;
	status_t status;

	ntcl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status(status),
		.cmd(cmd)
	);

	ntcl_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.out_data(out_data),
		.cmd(cmd),
		.status(status)
	);

endmodule

### rtl/ntcl_ctrl.sv
`include "ntc_thermistor_linearizer_unit_defines.svh"

module ntcl_ctrl
	import ntcl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input status_t status,
	output cmd_t cmd
);

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001,
		S_LG_INIT = 16'h0002,
		S_LG_ITER = 16'h0004,
		S_LG_ACC = 16'h0008,
		S_LN_MUL = 16'h0010,
		S_LN_RND = 16'h0020,
		S_MUL_NUM = 16'h0040,
		S_MUL_BD = 16'h0080,
		S_MUL_LQ = 16'h0100,
		S_DEN = 16'h0200,
		S_DIV_INIT = 16'h0400,
		S_DIV = 16'h0800,
		S_FIN = 16'h1000,
		S_BL_MUL = 16'h2000,
		S_UPD = 16'h4000,
		S_DONE = 16'h8000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0] sel_q, sel_d;
	op_t op;

	assign in_ready = (state_q == S_IDLE);
	assign cmd.op = op;
	assign cmd.lg_sel = sel_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		sel_d = sel_q;
		op = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op = OP_LOAD;
					sel_d = '0;
					state_d = S_LG_INIT;
				end
			end
			S_LG_INIT: begin
				if (status.rail) begin
					state_d = S_FIN;
				end else begin
					op = OP_LG_INIT;
					cnt_d = CNT_W'(LG_ITERS - 1);
					state_d = S_LG_ITER;
				end
			end
			S_LG_ITER: begin
				op = OP_LG_ITER;
				if (cnt_q == '0) begin
					state_d = S_LG_ACC;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_LG_ACC: begin
				op = OP_LG_ACC;
				if (sel_q == 2'd3) begin
					state_d = S_LN_MUL;
				end else begin
					sel_d = sel_q + 1'b1;
					state_d = S_LG_INIT;
				end
			end
			S_LN_MUL: begin
				op = OP_LN_MUL;
				state_d = S_LN_RND;
			end
			S_LN_RND: begin
				op = OP_LN_RND;
				state_d = S_MUL_NUM;
			end
			S_MUL_NUM: begin
				op = OP_MUL_NUM;
				state_d = S_MUL_BD;
			end
			S_MUL_BD: begin
				op = OP_MUL_BD;
				state_d = S_MUL_LQ;
			end
			S_MUL_LQ: begin
				op = OP_MUL_LQ;
				state_d = S_DEN;
			end
			S_DEN: begin
				op = OP_DEN;
				state_d = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				// skip the divider when the denominator is zero
				if (status.den_zero) begin
					state_d = S_FIN;
				end else begin
					op = OP_DIV_INIT;
					cnt_d = CNT_W'(DIV_BITS - 1);
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				op = OP_DIV_STEP;
				if (cnt_q == '0) begin
					state_d = S_FIN;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			S_FIN: begin
				op = OP_FIN;
				state_d = S_BL_MUL;
			end
			S_BL_MUL: begin
				op = OP_BL_MUL;
				state_d = S_UPD;
			end
			S_UPD: begin
				op = OP_UPD;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the request
				if (status.out_free) begin
					op = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			sel_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			sel_q <= sel_d;
		end
	end

	`NTCL_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && in_ready, state_q == S_LG_INIT)
	`NTCL_ASSERT_NEXT(a_div_ends, clk, arst_n, state_q == S_DIV && cnt_q == '0, state_q == S_FIN)
	`NTCL_ASSERT_NOW(a_out_when_free, clk, arst_n, op == OP_OUT, status.out_free)

endmodule

### rtl/ntcl_datapath.sv
`include "ntc_thermistor_linearizer_unit_defines.svh"

module ntcl_datapath
	import ntcl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [2:0] cfg_index,
	input logic [19:0] cfg_data,
	input in_item_t in_data,
	input logic out_ready,
	output logic out_valid,
	output out_item_t out_data,
	input cmd_t cmd,
	output status_t status
);

	// configuration
	logic [19:0] series_q, nominal_q;
	logic [13:0] beta_q;
	logic signed [12:0] offset_q;
	logic [15:0] alpha_q;
	logic high_q;

	// working registers
	logic [11:0] raw_q;
	logic rail_q;
	logic signed [22:0] lacc_q;
	logic [4:0] k_q;
	logic [30:0] m_q;
	logic [15:0] frac_q;
	logic [51:0] prod_q;
	logic signed [22:0] lnq_q;
	logic [28:0] num_q;
	logic [36:0] bd_q;
	logic signed [38:0] lq_q;
	logic signed [39:0] den_q;
	logic [38:0] dabs_q;
	logic [53:0] quo_q;
	logic [38:0] rem_q;
	logic dneg_q;
	logic signed [15:0] reading_q;
	logic ok_q;
	logic bneg_q;
	logic signed [15:0] smooth_q;
	logic have_q;
	out_item_t out_q;
	logic out_valid_q;

	// combinational helpers
	logic [13:0] sum;
	logic [11:0] samples [SAMPLE_FIELDS];
	logic [11:0] raw_d;
	logic [19:0] lg_x;
	logic [4:0] lg_k;
	logic [61:0] sq;
	logic [31:0] sq_top;
	logic [20:0] lg_val;
	logic lg_neg;
	logic [22:0] labs;
	logic [52:0] ln_round;
	logic [22:0] ln_mag;
	logic [13:0] beta_eff;
	logic [38:0] dabs_d;
	logic [39:0] rem_sh;
	logic signed [56:0] tk;
	logic signed [56:0] tc;
	logic signed [15:0] reading_d;
	logic signed [16:0] diff;
	logic [16:0] diff_abs;
	logic [33:0] step_sum;
	logic [16:0] step;
	logic signed [16:0] blended;

	assign samples[0] = in_data.sample_0;
	assign samples[1] = in_data.sample_1;
	assign samples[2] = in_data.sample_2;
	assign samples[3] = in_data.sample_3;

	always_comb begin
		sum = '0;
		for (int i = 0; i < SamplesUsed; i++) begin
			sum = sum + 14'(samples[i]);
		end
		raw_d = 12'(sum / SamplesUsed);
	end

	// log2 operand and top-bit position
	always_comb begin
		case (cmd.lg_sel)
			2'd0: lg_x = (series_q == '0) ? 20'd1 : series_q;
			2'd1: lg_x = (nominal_q == '0) ? 20'd1 : nominal_q;
			2'd2: lg_x = {8'd0, raw_q};
			default: lg_x = {8'd0, 12'(FULL_SCALE) - raw_q};
		endcase
		lg_k = '0;
		for (int i = 0; i < 20; i++) begin
			if (lg_x[i]) begin
				lg_k = 5'(i);
			end
		end
	end

	assign sq = 62'(m_q) * 62'(m_q);
	assign sq_top = sq[61:30];
	assign lg_val = {k_q, frac_q};
	assign lg_neg = (cmd.lg_sel == 2'd1) || (cmd.lg_sel == 2'd2 && high_q) ||
		(cmd.lg_sel == 2'd3 && !high_q);

	assign labs = lacc_q[22] ? 23'(-lacc_q) : 23'(lacc_q);
	assign ln_round = 53'(prod_q) + 53'd536870912;
	assign ln_mag = ln_round[52:30];
	assign beta_eff = (beta_q == '0) ? 14'd1 : beta_q;
	assign dabs_d = den_q[39] ? 39'(-den_q) : 39'(den_q);
	assign rem_sh = {rem_q, quo_q[DIV_BITS-1]};

	// kelvin to Celsius, offset and saturation
	always_comb begin
		tk = dneg_q ? -$signed({3'd0, quo_q}) : $signed({3'd0, quo_q});
		tc = tk - ZERO_C_Q8 + 57'(offset_q);
		if (rail_q) begin
			reading_d = FAIL_Q8;
		end else if (den_q == '0) begin
			reading_d = MAX_Q8;
		end else if (tc > 57'(MAX_Q8)) begin
			reading_d = MAX_Q8;
		end else if (tc < 57'(MIN_Q8)) begin
			reading_d = MIN_Q8;
		end else begin
			reading_d = tc[15:0];
		end
	end

	assign diff = 17'(reading_q) - 17'(smooth_q);
	assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
	assign step_sum = 34'(prod_q[32:0]) + 34'd32768;
	assign step = step_sum[32:16];
	assign blended = bneg_q ? 17'(smooth_q) - $signed(step) : 17'(smooth_q) + $signed(step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q <= SERIES_RST;
			nominal_q <= NOMINAL_RST;
			beta_q <= BETA_RST;
			offset_q <= '0;
			alpha_q <= '0;
			high_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SERIES: series_q <= cfg_data;
				CFG_NOMINAL: nominal_q <= cfg_data;
				CFG_BETA: beta_q <= cfg_data[13:0];
				CFG_OFFSET: offset_q <= cfg_data[12:0];
				CFG_ALPHA: alpha_q <= cfg_data[15:0];
				CFG_HIGH_SIDE: high_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
			have_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_UPD && ok_q) begin
				if (have_q && alpha_q != '0) begin
					smooth_q <= blended[15:0];
				end else begin
					smooth_q <= reading_q;
				end
				have_q <= 1'b1;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				raw_q <= raw_d;
				rail_q <= (raw_d <= 12'(RAIL_MARGIN)) ||
					(raw_d >= 12'(FULL_SCALE - RAIL_MARGIN));
				lacc_q <= '0;
			end
			OP_LG_INIT: begin
				k_q <= lg_k;
				m_q <= {11'd0, lg_x} << (5'd30 - lg_k);
				frac_q <= '0;
			end
			OP_LG_ITER: begin
				// square, renormalize, shift out one fraction bit
				if (sq_top[31]) begin
					m_q <= sq_top[31:1];
				end else begin
					m_q <= sq_top[30:0];
				end
				frac_q <= {frac_q[14:0], sq_top[31]};
			end
			OP_LG_ACC: begin
				if (lg_neg) begin
					lacc_q <= lacc_q - $signed({2'd0, lg_val});
				end else begin
					lacc_q <= lacc_q + $signed({2'd0, lg_val});
				end
			end
			OP_LN_MUL: prod_q <= 52'(labs[21:0]) * 52'(LN2_Q30);
			OP_LN_RND: lnq_q <= lacc_q[22] ? -$signed(ln_mag) : $signed(ln_mag);
			OP_MUL_NUM: num_q <= 29'(beta_eff) * 29'(T0_CENTI);
			OP_MUL_BD: bd_q <= 37'(beta_eff) * 37'(BETA_SCALE);
			OP_MUL_LQ: lq_q <= $signed({24'd0, T0_CENTI}) * 39'(lnq_q);
			OP_DEN: den_q <= $signed({3'd0, bd_q}) + 40'(lq_q);
			OP_DIV_INIT: begin
				dabs_q <= dabs_d;
				dneg_q <= den_q[39];
				quo_q <= {num_q, 24'd0} + 54'(dabs_d >> 1);
				rem_q <= '0;
			end
			OP_DIV_STEP: begin
				if (rem_sh >= {1'b0, dabs_q}) begin
					rem_q <= 39'(rem_sh - {1'b0, dabs_q});
					quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[38:0];
					quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
				end
			end
			OP_FIN: begin
				reading_q <= reading_d;
				ok_q <= !rail_q && (reading_d > LOW_LIMIT_Q8) && (reading_d < HIGH_LIMIT_Q8);
			end
			OP_BL_MUL: begin
				prod_q <= 52'(33'(diff_abs) * 33'(alpha_q));
				bneg_q <= diff[16];
			end
			OP_OUT: begin
				out_q.raw_average <= raw_q;
				out_q.reading_q8 <= reading_q;
				out_q.reading_ok <= ok_q;
				out_q.temperature_q8 <= smooth_q;
				out_q.temperature_valid <= have_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign status.rail = rail_q;
	assign status.den_zero = (den_q == '0);
	assign status.out_free = !out_valid_q || out_ready;

	`NTCL_ASSERT_NEXT(a_rail_fails, clk, arst_n, cmd.op == OP_FIN && rail_q,
		reading_q == FAIL_Q8 && !ok_q)
	`NTCL_ASSERT_NEXT(a_ok_sets_have, clk, arst_n, cmd.op == OP_UPD && ok_q, have_q)

endmodule
